// ===== hdl/bpa_pkg.sv =====
// shared types, codes and helpers for the buddy page allocator
`timescale 1ns / 1ps
package bpa_pkg;

	localparam int RANK_LIMIT_DEF = 16;
	localparam int MAX_PAGES_DEF  = 65536;

	localparam logic [16:0] NIL_LINK = 17'h10000;

	// operation codes
	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_QRANK = 3'd2;
	localparam logic [2:0] OP_QCNT  = 3'd3;
	localparam logic [2:0] OP_INIT  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] page;
		logic [4:0]  rank;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] block_page;
		logic [16:0] answer;
	} res_t;

	typedef struct packed {
		logic [4:0] rank;
		logic       free;
	} meta_t;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		meta_t       data;
	} meta_wr_t;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [16:0] data;
	} link_wr_t;

	// block size in pages for a rank of at least one
	function automatic logic [17:0] blk_size(input logic [4:0] r);
		return 18'(1) << (r - 5'd1);
	endfunction

	// page sits on a block boundary of the given rank
	function automatic logic is_aligned(input logic [16:0] pg, input logic [4:0] r);
		logic [17:0] mask;
		mask = blk_size(r) - 18'd1;
		return ({1'b0, pg} & mask) == 18'd0;
	endfunction

endpackage

// ===== hdl/bpa_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bpa_core.sv =====
// sequencer that walks free lists and page metadata one step per cycle
`timescale 1ns / 1ps
module bpa_core #(
	parameter int RANK_LIMIT = bpa_pkg::RANK_LIMIT_DEF,
	parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bpa_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done,
	output bpa_pkg::res_t     result,
	input  logic [16:0]       pool_pages,
	output bpa_pkg::meta_wr_t meta_wr,
	output logic [15:0]       meta_raddr,
	input  bpa_pkg::meta_t    meta_rdata,
	output bpa_pkg::link_wr_t next_wr,
	output logic [15:0]       next_raddr,
	input  logic [16:0]       next_rdata,
	output bpa_pkg::link_wr_t prev_wr,
	output logic [15:0]       prev_raddr,
	input  logic [16:0]       prev_rdata
);
	import bpa_pkg::*;

	localparam int          RW    = $clog2(RANK_LIMIT + 1);
	localparam int          NR    = RANK_LIMIT + 1;
	localparam logic [17:0] PAGES = 18'(MAX_PAGES);
	localparam logic [4:0]  TOPR  = 5'(RANK_LIMIT);

	// sequencer states
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_MARK   = 5'd1;
	localparam logic [4:0] S_U0     = 5'd2;
	localparam logic [4:0] S_U1     = 5'd3;
	localparam logic [4:0] S_UW     = 5'd4;
	localparam logic [4:0] S_L0     = 5'd5;
	localparam logic [4:0] S_L1     = 5'd6;
	localparam logic [4:0] S_A0     = 5'd7;
	localparam logic [4:0] S_ASCAN  = 5'd8;
	localparam logic [4:0] S_ASPLIT = 5'd9;
	localparam logic [4:0] S_ALINK  = 5'd10;
	localparam logic [4:0] S_F0     = 5'd11;
	localparam logic [4:0] S_F1     = 5'd12;
	localparam logic [4:0] S_FM     = 5'd13;
	localparam logic [4:0] S_FR     = 5'd14;
	localparam logic [4:0] S_FC     = 5'd15;
	localparam logic [4:0] S_FU     = 5'd16;
	localparam logic [4:0] S_FL     = 5'd17;
	localparam logic [4:0] S_Q0     = 5'd18;
	localparam logic [4:0] S_Q1     = 5'd19;
	localparam logic [4:0] S_C0     = 5'd20;
	localparam logic [4:0] S_I0     = 5'd21;
	localparam logic [4:0] S_IL     = 5'd22;
	localparam logic [4:0] S_ILK    = 5'd23;
	localparam logic [4:0] S_IA     = 5'd24;
	localparam logic [4:0] S_DONE   = 5'd25;

	logic [4:0]  state_q, ret_q;
	logic [2:0]  op_q;
	logic [4:0]  rk_q;
	logic [16:0] pg_q;
	logic [5:0]  r_q;
	logic [4:0]  s_q;
	logic [16:0] blk_q, bud_q, h_q;
	logic [16:0] sa_pg_q;
	logic [4:0]  sa_r_q;
	logic        sa_fr_q;
	logic [17:0] m_q, mend_q;
	logic [16:0] piu_q, rem_q, at_q;
	logic [1:0]  st_q;
	logic [16:0] ans_q;
	logic [16:0] head_q [NR];
	logic [16:0] cnt_q  [NR];
	logic [4:0]  top_q;

	logic        rk_ok;
	logic [RW-1:0] rki, sai, rqi, topi;
	logic [16:0] cnt_sa, cnt_dec;
	logic [17:0] sz_r, fbud, isz;
	logic        mark_go;

	assign rk_ok   = (rk_q != 5'd0) && (rk_q <= TOPR);
	assign rki     = rk_q[RW-1:0];
	assign sai     = sa_r_q[RW-1:0];
	assign rqi     = r_q[RW-1:0];
	assign topi    = top_q[RW-1:0];
	assign cnt_sa  = cnt_q[sai];
	assign cnt_dec = (cnt_sa != 17'd0) ? cnt_sa - 17'd1 : cnt_sa;
	assign sz_r    = blk_size(r_q[4:0]);
	assign fbud    = {1'b0, pg_q} ^ sz_r;
	assign isz     = sz_r;
	assign mark_go = (m_q < mend_q) && (m_q < PAGES);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// result fields
	always_comb begin
		result.status     = st_q;
		result.block_page = (op_q == OP_ALLOC && st_q == ST_OK) ? blk_q[15:0] : 16'd0;
		result.answer     = ans_q;
	end

	// memory port control
	always_comb begin
		meta_wr    = '0;
		next_wr    = '0;
		prev_wr    = '0;
		meta_raddr = pg_q[15:0];
		next_raddr = sa_pg_q[15:0];
		prev_raddr = sa_pg_q[15:0];
		case (state_q)
			S_MARK: begin
				meta_wr.we        = mark_go;
				meta_wr.addr      = m_q[15:0];
				meta_wr.data.rank = sa_r_q;
				meta_wr.data.free = sa_fr_q;
			end
			S_U1: begin
				next_wr.we   = ({1'b0, prev_rdata} < PAGES);
				next_wr.addr = prev_rdata[15:0];
				next_wr.data = next_rdata;
				prev_wr.we   = ({1'b0, next_rdata} < PAGES);
				prev_wr.addr = next_rdata[15:0];
				prev_wr.data = prev_rdata;
			end
			S_L0: begin
				next_wr.we   = 1'b1;
				next_wr.addr = sa_pg_q[15:0];
				next_wr.data = head_q[sai];
				prev_wr.we   = 1'b1;
				prev_wr.addr = sa_pg_q[15:0];
				prev_wr.data = NIL_LINK;
			end
			S_L1: begin
				prev_wr.we   = ({1'b0, h_q} < PAGES);
				prev_wr.addr = h_q[15:0];
				prev_wr.data = sa_pg_q;
			end
			S_FR: begin
				meta_raddr = bud_q[15:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			top_q   <= 5'd0;
			piu_q   <= 17'd0;
			for (int i = 0; i < NR; i++) begin
				head_q[i] <= NIL_LINK;
				cnt_q[i]  <= 17'd0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= cmd.operation;
						pg_q  <= {1'b0, cmd.page};
						rk_q  <= cmd.rank;
						st_q  <= ST_INVALID;
						ans_q <= 17'd0;
						blk_q <= 17'd0;
						case (cmd.operation)
							OP_ALLOC: state_q <= S_A0;
							OP_FREE:  state_q <= S_F0;
							OP_QRANK: state_q <= S_Q0;
							OP_QCNT:  state_q <= S_C0;
							OP_INIT:  state_q <= S_I0;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				// mark pages of one block, one page a cycle
				S_MARK: begin
					if (mark_go) begin
						m_q <= m_q + 18'd1;
					end else begin
						state_q <= ret_q;
					end
				end
				// unlink: read links, then patch neighbors
				S_U0: begin
					state_q <= S_U1;
				end
				S_U1: begin
					if ({1'b0, prev_rdata} >= PAGES) begin
						head_q[sai] <= next_rdata;
					end
					cnt_q[sai] <= cnt_dec;
					if (cnt_dec == 17'd0 && sa_r_q == top_q) begin
						state_q <= S_UW;
					end else begin
						state_q <= ret_q;
					end
				end
				// walk top rank down past empty lists
				S_UW: begin
					if (top_q != 5'd0 && cnt_q[topi] == 17'd0) begin
						top_q <= top_q - 5'd1;
					end else begin
						state_q <= ret_q;
					end
				end
				// link at list head
				S_L0: begin
					h_q     <= head_q[sai];
					state_q <= S_L1;
				end
				S_L1: begin
					head_q[sai] <= sa_pg_q;
					cnt_q[sai]  <= cnt_sa + 17'd1;
					if (sa_r_q > top_q) begin
						top_q <= sa_r_q;
					end
					state_q <= ret_q;
				end
				// alloc: exact list first
				S_A0: begin
					if (!rk_ok) begin
						state_q <= S_DONE;
					end else if ({1'b0, head_q[rki]} < PAGES) begin
						blk_q   <= head_q[rki];
						s_q     <= rk_q;
						sa_pg_q <= head_q[rki];
						sa_r_q  <= rk_q;
						ret_q   <= S_ASPLIT;
						state_q <= S_U0;
					end else begin
						st_q    <= ST_NOSPACE;
						r_q     <= {1'b0, rk_q} + 6'd1;
						state_q <= S_ASCAN;
					end
				end
				// alloc: search larger ranks
				S_ASCAN: begin
					if (r_q <= {1'b0, top_q} && r_q <= {1'b0, TOPR}) begin
						if ({1'b0, head_q[rqi]} < PAGES) begin
							blk_q   <= head_q[rqi];
							s_q     <= r_q[4:0];
							sa_pg_q <= head_q[rqi];
							sa_r_q  <= r_q[4:0];
							ret_q   <= S_ASPLIT;
							state_q <= S_U0;
						end else begin
							r_q <= r_q + 6'd1;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				// alloc: split off upper halves, then mark the block taken
				S_ASPLIT: begin
					if (s_q > rk_q) begin
						bud_q   <= 17'(({1'b0, blk_q} + blk_size(s_q - 5'd1)));
						s_q     <= s_q - 5'd1;
						sa_pg_q <= 17'(({1'b0, blk_q} + blk_size(s_q - 5'd1)));
						sa_r_q  <= s_q - 5'd1;
						sa_fr_q <= 1'b1;
						m_q     <= {1'b0, blk_q} + blk_size(s_q - 5'd1);
						mend_q  <= {1'b0, blk_q} + blk_size(s_q - 5'd1)
							+ blk_size(s_q - 5'd1);
						ret_q   <= S_ALINK;
						state_q <= S_MARK;
					end else begin
						st_q    <= ST_OK;
						sa_pg_q <= blk_q;
						sa_r_q  <= rk_q;
						sa_fr_q <= 1'b0;
						m_q     <= {1'b0, blk_q};
						mend_q  <= {1'b0, blk_q} + blk_size(rk_q);
						ret_q   <= S_DONE;
						state_q <= S_MARK;
					end
				end
				S_ALINK: begin
					sa_pg_q <= bud_q;
					sa_r_q  <= s_q;
					ret_q   <= S_ASPLIT;
					state_q <= S_L0;
				end
				// free: check page, read its metadata
				S_F0: begin
					state_q <= (pg_q < piu_q) ? S_F1 : S_DONE;
				end
				S_F1: begin
					if (!meta_rdata.free && meta_rdata.rank != 5'd0 &&
						meta_rdata.rank <= TOPR && is_aligned(pg_q, meta_rdata.rank)) begin
						r_q     <= {1'b0, meta_rdata.rank};
						sa_pg_q <= pg_q;
						sa_r_q  <= meta_rdata.rank;
						sa_fr_q <= 1'b1;
						m_q     <= {1'b0, pg_q};
						mend_q  <= {1'b0, pg_q} + blk_size(meta_rdata.rank);
						ret_q   <= S_FM;
						state_q <= S_MARK;
					end else begin
						state_q <= S_DONE;
					end
				end
				// free: look at the buddy
				S_FM: begin
					if (r_q < {1'b0, TOPR} && fbud < {1'b0, piu_q} &&
						fbud + sz_r <= {1'b0, piu_q}) begin
						bud_q   <= fbud[16:0];
						state_q <= S_FR;
					end else begin
						state_q <= S_FL;
					end
				end
				S_FR: begin
					state_q <= S_FC;
				end
				S_FC: begin
					if (meta_rdata.free && {1'b0, meta_rdata.rank} == r_q) begin
						sa_pg_q <= bud_q;
						sa_r_q  <= r_q[4:0];
						ret_q   <= S_FU;
						state_q <= S_U0;
					end else begin
						state_q <= S_FL;
					end
				end
				// free: merge into the next rank
				S_FU: begin
					if (bud_q < pg_q) begin
						pg_q    <= bud_q;
						sa_pg_q <= bud_q;
						m_q     <= {1'b0, bud_q};
						mend_q  <= {1'b0, bud_q} + blk_size(r_q[4:0] + 5'd1);
					end else begin
						sa_pg_q <= pg_q;
						m_q     <= {1'b0, pg_q};
						mend_q  <= {1'b0, pg_q} + blk_size(r_q[4:0] + 5'd1);
					end
					r_q     <= r_q + 6'd1;
					sa_r_q  <= r_q[4:0] + 5'd1;
					sa_fr_q <= 1'b1;
					ret_q   <= S_FM;
					state_q <= S_MARK;
				end
				S_FL: begin
					st_q    <= ST_OK;
					sa_pg_q <= pg_q;
					sa_r_q  <= r_q[4:0];
					ret_q   <= S_DONE;
					state_q <= S_L0;
				end
				// query rank
				S_Q0: begin
					state_q <= (pg_q < piu_q) ? S_Q1 : S_DONE;
				end
				S_Q1: begin
					if (meta_rdata.free || (meta_rdata.rank != 5'd0 &&
						meta_rdata.rank <= TOPR && is_aligned(pg_q, meta_rdata.rank))) begin
						st_q  <= ST_OK;
						ans_q <= {12'd0, meta_rdata.rank};
					end
					state_q <= S_DONE;
				end
				// query free count
				S_C0: begin
					if (rk_ok) begin
						st_q  <= ST_OK;
						ans_q <= cnt_q[rki];
					end
					state_q <= S_DONE;
				end
				// init: empty lists, then carve the pool
				S_I0: begin
					for (int i = 0; i < NR; i++) begin
						head_q[i] <= NIL_LINK;
						cnt_q[i]  <= 17'd0;
					end
					top_q <= 5'd0;
					if ({1'b0, pool_pages} > PAGES) begin
						piu_q   <= 17'd0;
						st_q    <= ST_NOSPACE;
						state_q <= S_DONE;
					end else begin
						piu_q   <= pool_pages;
						rem_q   <= pool_pages;
						at_q    <= 17'd0;
						r_q     <= {1'b0, TOPR};
						state_q <= S_IL;
					end
				end
				S_IL: begin
					if (r_q == 6'd0) begin
						st_q    <= ST_OK;
						state_q <= S_DONE;
					end else if ({1'b0, rem_q} >= isz) begin
						sa_pg_q <= at_q;
						sa_r_q  <= r_q[4:0];
						sa_fr_q <= 1'b1;
						m_q     <= {1'b0, at_q};
						mend_q  <= {1'b0, at_q} + isz;
						ret_q   <= S_ILK;
						state_q <= S_MARK;
					end else begin
						r_q <= r_q - 6'd1;
					end
				end
				S_ILK: begin
					ret_q   <= S_IA;
					state_q <= S_L0;
				end
				S_IA: begin
					at_q    <= 17'({1'b0, at_q} + isz);
					rem_q   <= 17'({1'b0, rem_q} - isz);
					state_q <= S_IL;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/buddy_page_allocator_top.sv =====
// buddy page allocator top level: config register, page metadata rams, sequencer
// alloc and free time grows with the pages marked and with each split or merge
// init: time grows with pool_pages and the carved blocks; one page marked per cycle
// throughput: one command at a time, the next start is taken the cycle after done
// reset: lists empty, pool of zero pages, pool_pages register zero; page rams not cleared
`timescale 1ns / 1ps
module buddy_page_allocator_top #(
	parameter int RANK_LIMIT = bpa_pkg::RANK_LIMIT_DEF,
	parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bpa_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output bpa_pkg::res_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import bpa_pkg::*;

	localparam int AW = $clog2(MAX_PAGES);

	logic [16:0] pool_q;
	meta_wr_t    meta_wr;
	link_wr_t    next_wr, prev_wr;
	logic [15:0] meta_raddr, next_raddr, prev_raddr;
	meta_t       meta_rdata;
	logic [16:0] next_rdata, prev_rdata;

	// config register at address zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= 17'd0;
		end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
			pool_q <= pwdata[16:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = {15'd0, pool_q};

	// sequencer
	bpa_core #(
		.RANK_LIMIT (RANK_LIMIT),
		.MAX_PAGES  (MAX_PAGES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.pool_pages (pool_q),
		.meta_wr    (meta_wr),
		.meta_raddr (meta_raddr),
		.meta_rdata (meta_rdata),
		.next_wr    (next_wr),
		.next_raddr (next_raddr),
		.next_rdata (next_rdata),
		.prev_wr    (prev_wr),
		.prev_raddr (prev_raddr),
		.prev_rdata (prev_rdata)
	);

	// per-page rank and free mark
	bpa_ram #(
		.WIDTH ($bits(meta_t)),
		.DEPTH (MAX_PAGES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_wr.we),
		.waddr (meta_wr.addr[AW-1:0]),
		.wdata (meta_wr.data),
		.raddr (meta_raddr[AW-1:0]),
		.rdata (meta_rdata)
	);

	// forward links
	bpa_ram #(
		.WIDTH (17),
		.DEPTH (MAX_PAGES)
	) u_next_ram (
		.clk   (clk),
		.we    (next_wr.we),
		.waddr (next_wr.addr[AW-1:0]),
		.wdata (next_wr.data),
		.raddr (next_raddr[AW-1:0]),
		.rdata (next_rdata)
	);

	// backward links
	bpa_ram #(
		.WIDTH (17),
		.DEPTH (MAX_PAGES)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_wr.we),
		.waddr (prev_wr.addr[AW-1:0]),
		.wdata (prev_wr.data),
		.raddr (prev_raddr[AW-1:0]),
		.rdata (prev_rdata)
	);

endmodule

// ===== hdl/bpa_checker.sv =====
// port level checks for the buddy page allocator, bound to the top level
`timescale 1ns / 1ps
module bpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input bpa_pkg::cmd_t cmd,
	input logic          busy,
	input logic          done,
	input bpa_pkg::res_t result
);
	import bpa_pkg::*;

	// an accepted command keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result is shown while busy and lasts one cycle
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	// status code is defined and failed results carry no block page
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_INVALID ||
			result.status == ST_NOSPACE))
		else $error("undefined status");

	a_fail_page: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.block_page == 16'd0)
		else $error("block page set on failed transaction");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);
